// ===== design/sha_pkg.sv =====
package sha_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] KIND_ABSORB     = 2'd0;
	localparam logic [1:0] KIND_ABSORB_FIN = 2'd1;
	localparam logic [1:0] KIND_FIN        = 2'd2;

	localparam logic [1:0] OP_ABSORB     = 2'd0;
	localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
	localparam logic [1:0] OP_FIN        = 2'd2;

	localparam logic [7:0] PAD_MARKER = 8'h80;
	localparam logic [5:0] LEN_SLOT   = 6'd56;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_INDEX = 3'd7;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} item_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== design/sha_front.sv =====
module sha_front
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	output logic       push,
	output item_t      push_item,
	input  logic       q_full
);

	logic  vld_s1;
	item_t item_s1;
	logic  accept;
	logic  keep;
	item_t cls;

	assign in_stall  = vld_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = vld_s1 && !q_full;
	assign push_item = item_s1;

	// classify; the unused opcode is taken and dropped
	always_comb begin
		keep     = 1'b1;
		cls.data = data_byte;
		case (opcode)
			OP_ABSORB:     cls.kind = KIND_ABSORB;
			OP_ABSORB_FIN: cls.kind = KIND_ABSORB_FIN;
			OP_FIN:        cls.kind = KIND_FIN;
			default: begin
				cls.kind = KIND_FIN;
				keep     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== design/sha_fifo.sv =====
module sha_fifo
	import sha_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== design/sha_back.sv =====
module sha_back
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       q_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_FOLD  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_ZERO  = 3'd4;
	localparam logic [2:0] S_LEN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]   state_q;
	logic [2:0]   ret_q;
	logic [5:0]   cnt_q;
	logic [5:0]   rnd_q;
	logic [63:0]  bits_q;
	logic [2:0]   idx_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  wk_q [8];
	logic [511:0] win_q;
	logic         out_valid_q;
	logic [31:0]  dw_q;
	logic [2:0]   wi_q;
	logic         lw_q;

	logic         shift_en;
	logic [7:0]   shift_byte;
	logic [2:0]   next_st;
	logic [2:0]   ret_st;
	logic         blk_done;
	logic         out_load;

	logic [31:0] w0, w1, w9, w14, w16;
	logic [31:0] t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign out_valid   = out_valid_q;
	assign digest_word = dw_q;
	assign word_index  = wi_q;
	assign last_word   = lw_q;

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign blk_done = shift_en && (cnt_q == LAST_BYTE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		shift_en   = 1'b0;
		shift_byte = q_item.data;
		next_st    = state_q;
		ret_st     = state_q;
		case (state_q)
			S_IDLE: begin
				shift_en = pop && (q_item.kind != KIND_FIN);
				next_st  = (q_item.kind == KIND_ABSORB) ? S_IDLE : S_MARK;
				ret_st   = next_st;
			end
			S_MARK: begin
				shift_en   = 1'b1;
				shift_byte = PAD_MARKER;
				next_st    = S_ZERO;
				ret_st     = S_ZERO;
			end
			S_ZERO: begin
				shift_en   = (cnt_q != LEN_SLOT);
				shift_byte = 8'h00;
				next_st    = shift_en ? S_ZERO : S_LEN;
				ret_st     = S_ZERO;
			end
			S_LEN: begin
				shift_en   = 1'b1;
				shift_byte = bits_q[63:56];
				next_st    = S_LEN;
				ret_st     = S_OUT;
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	// message schedule runs in place: w[t] always sits in the top word
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w16 = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
		+ (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

	assign t1 = wk_q[7] + (rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25))
		+ ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6])) + round_k(rnd_q) + w0;
	assign t2 = (rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22))
		+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			rnd_q       <= '0;
			bits_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else begin
			if (pop && (q_item.kind != KIND_FIN)) begin
				bits_q <= bits_q + 64'd8;
			end
			if (state_q == S_LEN) begin
				bits_q <= {bits_q[55:0], 8'h00};
			end
			if (blk_done) begin
				cnt_q   <= '0;
				rnd_q   <= '0;
				ret_q   <= ret_st;
				state_q <= S_ROUND;
			end else if (shift_en) begin
				cnt_q   <= cnt_q + 1'b1;
				state_q <= next_st;
			end else if (state_q == S_IDLE && pop) begin
				state_q <= next_st;
			end else if (state_q == S_ZERO) begin
				state_q <= next_st;
			end
			if (state_q == S_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_q <= S_FOLD;
				end
			end
			if (state_q == S_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + wk_q[i];
				end
				state_q <= ret_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 1'b1;
				if (idx_q == LAST_INDEX) begin
					// digest is out; start the next message fresh
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= IV[i];
					end
					bits_q  <= '0;
					state_q <= S_IDLE;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= {win_q[503:0], shift_byte};
		end
		if (blk_done) begin
			for (int i = 0; i < 8; i++) begin
				wk_q[i] <= chain_q[i];
			end
		end
		if (state_q == S_ROUND) begin
			win_q   <= {win_q[479:0], w16};
			wk_q[7] <= wk_q[6];
			wk_q[6] <= wk_q[5];
			wk_q[5] <= wk_q[4];
			wk_q[4] <= wk_q[3] + t1;
			wk_q[3] <= wk_q[2];
			wk_q[2] <= wk_q[1];
			wk_q[1] <= wk_q[0];
			wk_q[0] <= t1 + t2;
		end
		if (out_load) begin
			dw_q <= chain_q[idx_q];
			wi_q <= idx_q;
			lw_q <= (idx_q == LAST_INDEX);
		end
	end

endmodule

// ===== design/sha256_message_hasher_unit.sv =====
// channel | direction | handshake           | fields
// in      | input     | in_valid / in_stall   | opcode[1:0], data_byte[7:0]
// out     | output    | out_valid / out_stall | digest_word[31:0], word_index[2:0], last_word
//
// The back end takes one queued byte per cycle into the schedule window while it is
// idle; a full block then holds it for the rounds and the fold on the single round
// unit. A finish pads byte by byte up to the block end (one or two more blocks), then
// issues eight words. Reset loads the initial hash values and clears all counters;
// no clearing pass. A stalled output holds its word; the front and queue take up to
// QUEUE_DEPTH + 1 more words (five by default).
module sha256_message_hasher_unit
	import sha_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	item_t pop_item;
	logic  q_empty;

	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	sha_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	sha_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

// ===== dv/sha256_message_hasher_unit_tb.sv =====
`timescale 1ns / 1ps

module sha256_message_hasher_unit_tb;
	import sha_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_ITEMS = 300;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	class digest_predictor;
		typedef struct {
			logic [31:0] word;
			logic [2:0]  index;
			logic        is_last;
		} digest_entry_t;

		logic [31:0] chain [8];
		logic [7:0]  block [64];
		int unsigned fill;
		logic [63:0] bit_count;
		digest_entry_t expected_words [$];
		int errors;
		int messages;
		int bytes_taken;
		int ignored;
		int checked;

		function new();
			errors = 0;
			messages = 0;
			bytes_taken = 0;
			ignored = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			chain = START_HASH;
			fill = 0;
			bit_count = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] s0, s1, ch, mj, t1, t2, wt, w15, w2;
			int i;
			int t;
			for (i = 0; i < 16; i++)
				w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
			v = chain;
			for (t = 0; t < 64; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					// extend the schedule in place over a 16-entry window
					w15 = w[(t - 15) & 15];
					w2 = w[(t - 2) & 15];
					wt = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(t - 7) & 15]
						+ (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[t & 15];
					w[t & 15] = wt;
				end
				s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_CONST[t] + wt;
				s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2 = s0 + mj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void take_byte(logic [7:0] b);
			block[fill] = b;
			fill++;
			bytes_taken++;
			if (fill == 64) begin
				compress();
				bit_count = bit_count + 64'd512;
				fill = 0;
			end
		endfunction

		function void close_message();
			int unsigned n;
			logic [63:0] total;
			int i;
			n = fill;
			block[n] = PAD_MARKER;
			for (i = n + 1; i < 64; i++)
				block[i] = 8'h00;
			// no room for the length: flush this block and pad a fresh one
			if (n >= 56) begin
				compress();
				for (i = 0; i < 64; i++)
					block[i] = 8'h00;
			end
			total = bit_count + 64'(n) * 64'd8;
			for (i = 0; i < 8; i++)
				block[63 - i] = total[8*i +: 8];
			compress();
			for (i = 0; i < 8; i++)
				expected_words.push_back('{word: chain[i], index: 3'(i), is_last: (i == 7)});
			messages++;
			restart();
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] b);
			case (op)
				OP_ABSORB: begin
					take_byte(b);
				end
				OP_ABSORB_FIN: begin
					take_byte(b);
					close_message();
				end
				OP_FIN: begin
					close_message();
				end
				default: begin
					ignored++;
				end
			endcase
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [31:0] w, logic [2:0] idx, logic lw);
			digest_entry_t e;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected digest word %h index %0d", w, idx));
				return;
			end
			e = expected_words.pop_front();
			checked++;
			if (w !== e.word)
				report($sformatf("digest_word %h, want %h (index %0d)", w, e.word, e.index));
			if (idx !== e.index)
				report($sformatf("word_index %0d, want %0d", idx, e.index));
			if (lw !== e.is_last)
				report($sformatf("last_word %b, want %b (index %0d)", lw, e.is_last, e.index));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_predictor board = new();
	bit steady = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	sha256_message_hasher_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// check output words, throttle the output, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_word(digest_word, word_index, last_word);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
			if (hold_left == 0) begin
				hold_left = pick_gap();
				out_stall <= 1'b0;
			end else begin
				hold_left--;
				out_stall <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		board.note_item(op, b);
	endtask

	task automatic send_message(input int len, input bit close_on_byte);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_UNUSED, 8'($urandom));
			if (close_on_byte && i == len - 1)
				send_item(OP_ABSORB_FIN, 8'($urandom));
			else
				send_item(OP_ABSORB, 8'($urandom));
		end
		if (!close_on_byte)
			send_item(OP_FIN, 8'($urandom));
	endtask

	initial begin
		int len;
		int shape;
		int sent;
		bit close_on_byte;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, twice in a row, and a stray unused opcode with nothing pending
		send_item(OP_FIN, 8'hff);
		send_item(OP_FIN, 8'h00);
		send_item(OP_UNUSED, 8'h00);
		// "abc" with an unused opcode in the middle
		send_item(OP_ABSORB, 8'h61);
		send_item(OP_ABSORB, 8'h62);
		send_item(OP_UNUSED, 8'hff);
		send_item(OP_ABSORB_FIN, 8'h63);
		// single-byte extremes, closed on the byte and closed separately, then a two-byte message
		send_item(OP_ABSORB_FIN, 8'hff);
		send_item(OP_ABSORB_FIN, 8'h00);
		send_item(OP_ABSORB, 8'hff);
		send_item(OP_FIN, 8'hff);
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_ABSORB, 8'haa);
		send_item(OP_FIN, 8'h55);

		while (sent < RANDOM_ITEMS) begin
			shape = $urandom_range(0, 9);
			case (shape)
				0, 1, 2, 3: len = $urandom_range(0, 12);
				4, 5:       len = $urandom_range(13, 50);
				6, 7:       len = $urandom_range(52, 66);
				8:          len = $urandom_range(118, 130);
				default:    len = $urandom_range(1, 3);
			endcase
			steady = ($urandom_range(0, 4) == 0);
			close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			send_message(len, close_on_byte);
			sent += close_on_byte ? len : len + 1;
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d bytes; %0d unused-opcode words dropped",
			board.messages, board.bytes_taken, board.ignored);
		$display("Checked %0d digest words, %0d mismatches", board.checked, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/sha_pkg.sv
design/sha_front.sv
design/sha_fifo.sv
design/sha_back.sv
design/sha256_message_hasher_unit.sv
dv/sha256_message_hasher_unit_tb.sv
